[hdl/roiqp_pkg.sv]
// roiqp_pkg: shared types, constants and helpers for the roi qp delta grid painter
// no dependencies
package roiqp_pkg;

  localparam int MAX_COLS        = 256;
  localparam int MAX_ROWS        = 256;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COL_W           = $clog2(MAX_COLS);
  localparam int ROW_W           = $clog2(MAX_ROWS);
  localparam int ADDR_W          = COL_W + ROW_W;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PAINT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_FRAME_W   = 3'd0,
    REG_FRAME_H   = 3'd1,
    REG_BLOCK     = 3'd2,
    REG_BG        = 3'd3,
    REG_KIND_EN   = 3'd4,
    REG_KIND_DLT  = 3'd5,
    REG_KIND_PADS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  box_kind;
    logic [16:0] box_left;
    logic [16:0] box_top;
    logic [16:0] box_width;
    logic [16:0] box_height;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
  } in_item_t;

  typedef struct packed {
    logic signed [6:0] cell_delta;
    logic [8:0]        grid_cols;
    logic [8:0]        grid_rows;
  } out_item_t;

  // one job for the back end: a cell rectangle filled with a delta, lowered to a delta where smaller, or one cell read
  typedef enum logic [1:0] {
    JOB_FILL  = 2'd0,
    JOB_MIN   = 2'd1,
    JOB_READ  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [COL_W-1:0]  c0;
    logic [COL_W-1:0]  c1;
    logic [ROW_W-1:0]  r0;
    logic [ROW_W-1:0]  r1;
    logic signed [6:0] delta;
  } job_t;

  typedef struct packed {
    logic [COL_W:0] cols;
    logic [ROW_W:0] rows;
  } grid_dim_t;

  function automatic logic signed [6:0] clamp51(input logic signed [9:0] v);
    if (v < -10'sd51) return -7'sd51;
    if (v > 10'sd51) return 7'sd51;
    return v[6:0];
  endfunction

endpackage

[hdl/roiqp_front.sv]
// roiqp_front: accepts items, maps boxes to cell rectangles and pushes jobs
// depends on roiqp_pkg
module roiqp_front import roiqp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_item,
  output logic             front_busy,
  input  logic [12:0]      eff_w,
  input  logic [12:0]      eff_h,
  input  logic [6:0]       eff_b,
  input  grid_dim_t        dim,
  input  logic signed [6:0] bg_raw,
  input  logic [3:0]       kind_en,
  input  logic [31:0]      kind_dlt,
  input  logic [63:0]      kind_pads,
  output logic             job_push,
  output job_t             job,
  input  logic             job_full
);

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_EDGE, F_DIV, F_PUSH
  } fstate_t;

  fstate_t state_r, state_nxt;
  in_item_t item_r;
  logic halo_r, halo_nxt;
  logic signed [6:0] dlt_r;
  // corners in Q16 with sign room
  logic signed [19:0] ql_r, qt_r, qr_r, qb_r;
  logic signed [33:0] pl_r, pt_r, pr_r, pb_r;
  logic [12:0] x0_r, y0_r, x1_r, y1_r;
  logic [12:0] dq_r [4];
  logic [6:0]  div_cnt_r;
  logic        empty_r;

  logic signed [7:0] body;
  logic [15:0] pad;
  logic signed [6:0] halo_d;
  logic signed [8:0] hsum;

  always_comb begin
    body   = kind_dlt[8*item_r.box_kind +: 8];
    pad    = kind_pads[16*item_r.box_kind +: 16];
    hsum   = {body[7], body} + {{2{bg_raw[6]}}, bg_raw};
    halo_d = clamp51(10'(signed'((hsum + ((hsum < 0) ? 9'sd1 : 9'sd0)) >>> 1)));
  end

  function automatic logic [12:0] lo_edge(input logic signed [33:0] p, input logic [12:0] s);
    logic [33:0] v;
    v = 34'(p >>> COORD_FRAC_BITS);
    if (p < 0) return 13'd0;
    if (v > {21'd0, s}) return s;
    return v[12:0];
  endfunction

  function automatic logic [12:0] hi_edge(input logic signed [33:0] p, input logic [12:0] s);
    logic [33:0] v;
    v = 34'((p + 34'sd65535) >>> COORD_FRAC_BITS);
    if (p < 0) return 13'd0;
    if (v > {21'd0, s}) return s;
    return v[12:0];
  endfunction

  logic signed [19:0] ext_l, ext_t, ext_w, ext_h, ext_p;
  always_comb begin
    ext_l = 20'(in_item.box_left);
    ext_t = 20'(in_item.box_top);
    ext_w = 20'(in_item.box_width);
    ext_h = 20'(in_item.box_height);
    ext_p = 20'(pad);
  end

  always_comb begin
    state_nxt = state_r;
    halo_nxt  = halo_r;
    case (state_r)
      F_IDLE: if (in_valid) begin
        state_nxt = F_PUSH;
        if (in_item.opcode == OP_PAINT) begin
          state_nxt = F_MUL;
          halo_nxt  = 1'b0;
        end
      end
      F_MUL:  state_nxt = F_EDGE;
      F_EDGE: state_nxt = F_DIV;
      F_DIV:  if (div_cnt_r == 7'd0) state_nxt = F_PUSH;
      F_PUSH: if (!job_full || empty_r || item_r.opcode == OP_NONE) begin
        if (item_r.opcode == OP_PAINT && !halo_r && pad != 16'd0) begin
          state_nxt = F_MUL;
          halo_nxt  = 1'b1;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  logic [4:0] cnt_w;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      halo_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      halo_r  <= halo_nxt;
    end
    case (state_r)
      F_IDLE: begin
        item_r <= in_item;
        if (in_valid && in_item.opcode == OP_PAINT) begin
          // first pass is the halo when a pad is set, then the body
          ql_r <= ext_l;
          qt_r <= ext_t;
          qr_r <= ext_l + ext_w;
          qb_r <= ext_t + ext_h;
        end
      end
      F_MUL: begin
        if (pad != 16'd0 && !halo_r) begin
          pl_r <= 34'(ql_r - ext_p) * $signed({1'b0, eff_w});
          pt_r <= 34'(qt_r - ext_p) * $signed({1'b0, eff_h});
          pr_r <= 34'(qr_r + ext_p) * $signed({1'b0, eff_w});
          pb_r <= 34'(qb_r + ext_p) * $signed({1'b0, eff_h});
          dlt_r <= halo_d;
        end else begin
          pl_r <= 34'(ql_r) * $signed({1'b0, eff_w});
          pt_r <= 34'(qt_r) * $signed({1'b0, eff_h});
          pr_r <= 34'(qr_r) * $signed({1'b0, eff_w});
          pb_r <= 34'(qb_r) * $signed({1'b0, eff_h});
          dlt_r <= clamp51(10'(body));
        end
      end
      F_EDGE: begin
        x0_r <= lo_edge(pl_r, eff_w);
        y0_r <= lo_edge(pt_r, eff_h);
        x1_r <= hi_edge(pr_r, eff_w);
        y1_r <= hi_edge(pb_r, eff_h);
        empty_r <= (hi_edge(pr_r, eff_w) <= lo_edge(pl_r, eff_w)) ||
                   (hi_edge(pb_r, eff_h) <= lo_edge(pt_r, eff_h));
        div_cnt_r <= 7'd13;
      end
      F_DIV: begin
        // restoring divide by block size, one quotient bit per cycle
        if (div_cnt_r != 7'd0) begin
          div_cnt_r <= div_cnt_r - 7'd1;
        end
      end
      default: ;
    endcase
  end

  // restoring division state kept as remainders
  logic [12:0] rem_r [4];
  logic [12:0] num [4];
  logic [13:0] trial [4];
  assign cnt_w = div_cnt_r[4:0] - 5'd1;
  always_comb begin
    num[0] = x0_r; num[1] = y0_r; num[2] = x1_r - 13'd1; num[3] = y1_r - 13'd1;
  end
  always_ff @(posedge clk) begin
    if (state_r == F_EDGE) begin
      for (int i = 0; i < 4; i++) begin
        rem_r[i] <= 13'd0;
        dq_r[i]  <= 13'd0;
      end
    end else if (state_r == F_DIV && div_cnt_r != 7'd0) begin
      for (int i = 0; i < 4; i++) begin
        if (trial[i] >= {7'd0, eff_b}) begin
          rem_r[i] <= 13'(trial[i] - {7'd0, eff_b});
          dq_r[i][cnt_w[3:0]] <= 1'b1;
        end else begin
          rem_r[i] <= trial[i][12:0];
        end
      end
    end
  end
  always_comb begin
    for (int i = 0; i < 4; i++) trial[i] = {rem_r[i], num[i][cnt_w[3:0]]};
  end

  logic [12:0] c1_full, r1_full;
  always_comb begin
    c1_full = (dq_r[2] > 13'(dim.cols - 1'b1)) ? 13'(dim.cols - 1'b1) : dq_r[2];
    r1_full = (dq_r[3] > 13'(dim.rows - 1'b1)) ? 13'(dim.rows - 1'b1) : dq_r[3];
    job       = '0;
    job.c0    = dq_r[0][COL_W-1:0];
    job.r0    = dq_r[1][ROW_W-1:0];
    job.c1    = c1_full[COL_W-1:0];
    job.r1    = r1_full[ROW_W-1:0];
    job.delta = dlt_r;
    job.kind  = JOB_MIN;
    job_push  = 1'b0;
    case (opcode_t'(item_r.opcode))
      OP_CLEAR: begin
        job.kind  = JOB_FILL;
        job.c0    = '0;
        job.r0    = '0;
        job.c1    = COL_W'(dim.cols - 1'b1);
        job.r1    = ROW_W'(dim.rows - 1'b1);
        job.delta = clamp51(10'(bg_raw));
        job_push  = (state_r == F_PUSH) && !job_full;
      end
      OP_PAINT: job_push = (state_r == F_PUSH) && !job_full && !empty_r &&
                           kind_en[item_r.box_kind];
      OP_READ: begin
        job.kind = JOB_READ;
        job.c0   = ({1'b0, item_r.cell_col} > 9'(dim.cols - 1'b1)) ?
                   COL_W'(dim.cols - 1'b1) : COL_W'(item_r.cell_col);
        job.r0   = ({1'b0, item_r.cell_row} > 9'(dim.rows - 1'b1)) ?
                   ROW_W'(dim.rows - 1'b1) : ROW_W'(item_r.cell_row);
        job_push = (state_r == F_PUSH) && !job_full;
      end
      default: job_push = 1'b0;
    endcase
  end

  assign front_busy = (state_r != F_IDLE);

endmodule

[hdl/roiqp_queue.sv]
// roiqp_queue: short job queue between front and back
// depends on roiqp_pkg
module roiqp_queue import roiqp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic not_empty
);
  job_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_job;
  end
  assign head      = mem_r[rp_r];
  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
endmodule

[hdl/roiqp_back.sv]
// roiqp_back: walks job rectangles over the delta grid memory, answers reads
// depends on roiqp_pkg
module roiqp_back import roiqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      back_busy,
  output logic      rd_strobe,
  output logic signed [6:0] rd_delta
);
  typedef enum logic [1:0] { B_IDLE, B_READ, B_WRITE, B_ANSWER } bstate_t;

  bstate_t state_r, state_nxt;
  job_t job_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic signed [6:0] mem [MAX_COLS*MAX_ROWS];
  logic signed [6:0] rdata_r;
  logic last;

  assign last = (col_r == job_r.c1) && (row_r == job_r.r1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (job_valid) state_nxt = B_READ;
      B_READ:   state_nxt = (job_r.kind == JOB_READ) ? B_ANSWER : B_WRITE;
      B_WRITE:  if (last) state_nxt = B_IDLE; else state_nxt = B_READ;
      B_ANSWER: state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (state_r == B_IDLE) && job_valid;
    rd_strobe = (state_r == B_ANSWER);
    back_busy = (state_r != B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
    if (job_pop) begin
      job_r <= job;
      col_r <= job.c0;
      row_r <= job.r0;
    end
    if (state_r == B_READ) rdata_r <= mem[{row_r, col_r}];
    if (state_r == B_WRITE) begin
      if (job_r.kind == JOB_FILL || job_r.delta < rdata_r)
        mem[{row_r, col_r}] <= job_r.delta;
      if (col_r == job_r.c1) begin
        col_r <= job_r.c0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end
  assign rd_delta = rdata_r;
endmodule

[hdl/roi_qp_delta_grid_painter_unit.sv]
// roi qp delta grid painter top level: config registers, front, queue, back
// depends on roiqp_pkg, roiqp_front, roiqp_queue, roiqp_back
// A paint item passes the front per pass as multiply, edge, block divide and push,
// a halo pass and a body pass when the kind has a pad; the back then reads and
// writes each covered cell of a job in the single-port grid memory. A clear goes
// straight to push in the front, then the back reads and writes every grid cell.
// A read passes front push, the queue, back read and back answer before out_valid;
// the next item is taken once busy falls. busy stays high until the item's work is
// done, and after every register write while the grid size is recomputed; read
// results appear on out_valid for one cycle and cannot be held off.
module roi_qp_delta_grid_painter_unit import roiqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);
  logic [12:0] fw_r, fh_r;
  logic [6:0]  bs_r;
  logic signed [6:0] bg_r;
  logic [3:0]  ken_r;
  logic [31:0] kd_r;
  logic [63:0] kp_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd1920; fh_r <= 13'd1080; bs_r <= 7'd16; bg_r <= 7'sd6;
      ken_r <= '0; kd_r <= '0; kp_r <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_W:   fw_r  <= cfg_data[12:0];
        REG_FRAME_H:   fh_r  <= cfg_data[12:0];
        REG_BLOCK:     bs_r  <= cfg_data[6:0];
        REG_BG:        bg_r  <= cfg_data[6:0];
        REG_KIND_EN:   ken_r <= cfg_data[3:0];
        REG_KIND_DLT:  kd_r  <= cfg_data[31:0];
        REG_KIND_PADS: kp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [12:0] eff_w, eff_h;
  logic [6:0]  eff_b;
  grid_dim_t   dim;
  logic [12:0] cdiv, rdiv;
  always_comb begin
    eff_w = (fw_r == 13'd0) ? 13'd1 : (fw_r > 13'd4096 ? 13'd4096 : fw_r);
    eff_h = (fh_r == 13'd0) ? 13'd1 : (fh_r > 13'd4096 ? 13'd4096 : fh_r);
    eff_b = (bs_r < 7'd16) ? 7'd16 : (bs_r > 7'd64 ? 7'd64 : bs_r);
  end

  // grid size by two small serial dividers sharing one bit counter, rerun after every config write
  logic [3:0]  dcnt_r;
  logic [12:0] crem_r, rrem_r;
  logic        dim_ok_r;
  logic [13:0] ct, rt;
  logic [12:0] cnum, rnum;
  always_comb begin
    cnum = 13'(eff_w + 13'(eff_b) - 13'd1);
    rnum = 13'(eff_h + 13'(eff_b) - 13'd1);
    ct = {crem_r, cnum[dcnt_r]};
    rt = {rrem_r, rnum[dcnt_r]};
  end
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_valid) begin
      dcnt_r <= 4'd12; crem_r <= '0; rrem_r <= '0; cdiv <= '0; rdiv <= '0;
      dim_ok_r <= 1'b0;
    end else if (!dim_ok_r) begin
      if (ct >= {7'd0, eff_b}) begin
        crem_r <= 13'(ct - {7'd0, eff_b}); cdiv[dcnt_r] <= 1'b1;
      end else crem_r <= ct[12:0];
      if (rt >= {7'd0, eff_b}) begin
        rrem_r <= 13'(rt - {7'd0, eff_b}); rdiv[dcnt_r] <= 1'b1;
      end else rrem_r <= rt[12:0];
      if (dcnt_r == 4'd0) dim_ok_r <= 1'b1;
      else dcnt_r <= dcnt_r - 4'd1;
    end
  end
  always_comb begin
    dim.cols = (cdiv > 13'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(cdiv);
    dim.rows = (rdiv > 13'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(rdiv);
  end

  logic front_busy, back_busy, job_push, job_full, job_pop, q_ne, rd_strobe;
  job_t job_in, job_head;
  logic signed [6:0] rd_delta;

  roiqp_front u_front (
    .clk, .rst_n, .in_valid(start && !busy), .in_item(in_data), .front_busy,
    .eff_w, .eff_h, .eff_b, .dim, .bg_raw(bg_r), .kind_en(ken_r), .kind_dlt(kd_r),
    .kind_pads(kp_r), .job_push, .job(job_in), .job_full
  );
  roiqp_queue u_queue (
    .clk, .rst_n, .push(job_push), .push_job(job_in), .full(job_full),
    .pop(job_pop), .head(job_head), .not_empty(q_ne)
  );
  roiqp_back u_back (
    .clk, .rst_n, .job_valid(q_ne), .job(job_head), .job_pop, .back_busy,
    .rd_strobe, .rd_delta
  );

  assign busy = front_busy || back_busy || q_ne || !dim_ok_r;
  always_comb begin
    out_valid           = rd_strobe;
    out_data.cell_delta = rd_delta;
    out_data.grid_cols  = 9'(dim.cols);
    out_data.grid_rows  = 9'(dim.rows);
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full)) else $error("job pushed into full queue");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work in flight");
  a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    dim_ok_r |-> (dim.cols != '0 && dim.rows != '0)) else $error("empty grid");
endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for roi_qp_delta_grid_painter_unit
// depends on roiqp_pkg and the unit rtl; a scoreboard class predicts every read beat
// and plain tasks drive register writes and commands, commands with random gaps once enabled
module tb_top;
  import roiqp_pkg::*;

  class delta_grid_scoreboard;
    longint unsigned regs[7];
    byte grid[65536];
    out_item_t readouts[$];
    int mismatches;
    int checked;

    function new();
      regs = '{1920, 1080, 16, 6, 0, 0, 0};
      mismatches = 0;
      checked = 0;
    endfunction

    function int sat(longint v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : int'(v));
    endfunction

    function void write_reg(int idx, longint unsigned val);
      longint unsigned mask[7];
      mask = '{64'h1FFF, 64'h1FFF, 64'h7F, 64'h7F, 64'hF, 64'hFFFF_FFFF, '1};
      if (idx < 7) regs[idx] = val & mask[idx];
    endfunction

    function int frame_w();  return sat(regs[REG_FRAME_W], 1, 4096); endfunction
    function int frame_h();  return sat(regs[REG_FRAME_H], 1, 4096); endfunction
    function int blk();      return sat(regs[REG_BLOCK], 16, 64); endfunction
    function int bg_raw();   return int'($signed(regs[REG_BG][6:0])); endfunction
    function int n_cols();   return sat((frame_w() + blk() - 1) / blk(), 1, MAX_COLS); endfunction
    function int n_rows();   return sat((frame_h() + blk() - 1) / blk(), 1, MAX_ROWS); endfunction

    function int pix_lo(longint q, int size);
      longint v;
      v = q * size;
      if (v < 0) return 0;
      v = v >>> COORD_FRAC_BITS;
      return v > size ? size : int'(v);
    endfunction

    function int pix_hi(longint q, int size);
      longint v;
      v = q * size;
      if (v < 0) return 0;
      v = (v + (longint'(1) << COORD_FRAC_BITS) - 1) >>> COORD_FRAC_BITS;
      return v > size ? size : int'(v);
    endfunction

    function void paint_rect(longint l, longint t, longint r, longint b, int d);
      int x0, y0, x1, y1, c0, c1, r0, r1;
      x0 = pix_lo(l, frame_w());
      y0 = pix_lo(t, frame_h());
      x1 = pix_hi(r, frame_w());
      y1 = pix_hi(b, frame_h());
      if (x1 <= x0 || y1 <= y0) return;
      c0 = x0 / blk();
      r0 = y0 / blk();
      c1 = sat((x1 - 1) / blk(), 0, n_cols() - 1);
      r1 = sat((y1 - 1) / blk(), 0, n_rows() - 1);
      for (int row = r0; row <= r1; row++)
        for (int col = c0; col <= c1; col++)
          if (d < grid[row * MAX_COLS + col]) grid[row * MAX_COLS + col] = byte'(d);
    endfunction

    function void absorb_item(in_item_t it);
      int body, halo, k;
      longint pad, l, t, r, b;
      out_item_t o;
      case (opcode_t'(it.opcode))
        OP_CLEAR: begin
          for (int row = 0; row < n_rows(); row++)
            for (int col = 0; col < n_cols(); col++)
              grid[row * MAX_COLS + col] = byte'(sat(bg_raw(), -51, 51));
        end
        OP_PAINT: begin
          k = int'(it.box_kind);
          if (regs[REG_KIND_EN][k]) begin
            body = int'($signed(regs[REG_KIND_DLT][8*k +: 8]));
            pad = longint'(regs[REG_KIND_PADS][16*k +: 16]);
            l = longint'(it.box_left);
            t = longint'(it.box_top);
            r = l + longint'(it.box_width);
            b = t + longint'(it.box_height);
            if (pad > 0) begin
              halo = sat((body + bg_raw()) / 2, -51, 51);
              paint_rect(l - pad, t - pad, r + pad, b + pad, halo);
            end
            paint_rect(l, t, r, b, sat(body, -51, 51));
          end
        end
        OP_READ: begin
          o.cell_delta = 7'(grid[sat(longint'(it.cell_row), 0, n_rows() - 1) * MAX_COLS
                                 + sat(longint'(it.cell_col), 0, n_cols() - 1)]);
          o.grid_cols = 9'(n_cols());
          o.grid_rows = 9'(n_rows());
          readouts = {readouts, o};
        end
        default: ;
      endcase
    endfunction

    function void compare_readout(out_item_t got);
      out_item_t want;
      if (readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected read beat %p", got);
        return;
      end
      want = readouts.pop_front();
      checked++;
      if (got.cell_delta !== want.cell_delta || got.grid_cols !== want.grid_cols ||
          got.grid_rows !== want.grid_rows) begin
        mismatches++;
        if (mismatches <= 10)
          $display("read mismatch: delta %0d/%0d cols %0d/%0d rows %0d/%0d (exp/got)",
                   want.cell_delta, got.cell_delta, want.grid_cols, got.grid_cols,
                   want.grid_rows, got.grid_rows);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  delta_grid_scoreboard sb = new();
  int accepted;
  int stall_cycles;
  int settings_used;
  bit allow_gaps;

  roi_qp_delta_grid_painter_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.absorb_item(in_data);
      accepted++;
    end
    if (rst_n && out_valid) sb.compare_readout(out_data);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(int'(cfg_index), cfg_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 800000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(in_item_t it);
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || sb.readouts.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_setting(logic [12:0] w, logic [12:0] h, logic [6:0] bsz,
                               logic [6:0] bg, logic [3:0] en, logic [31:0] dl,
                               logic [63:0] pads);
    drain();
    write_cfg(REG_FRAME_W, 64'(w));
    write_cfg(REG_FRAME_H, 64'(h));
    write_cfg(REG_BLOCK, 64'(bsz));
    write_cfg(REG_BG, 64'(bg));
    write_cfg(REG_KIND_EN, 64'(en));
    write_cfg(REG_KIND_DLT, 64'(dl));
    write_cfg(REG_KIND_PADS, pads);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t cmd(opcode_t op, int k, int l, int t, int w, int h,
                                   int c, int r);
    in_item_t it;
    it.opcode = op;
    it.box_kind = 2'(k);
    it.box_left = 17'(l);
    it.box_top = 17'(t);
    it.box_width = 17'(w);
    it.box_height = 17'(h);
    it.cell_col = 8'(c);
    it.cell_row = 8'(r);
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    int sel;
    it = in_item_t'(88'({$urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 4) it.opcode = OP_CLEAR;
    else if (sel < 58) it.opcode = OP_PAINT;
    else if (sel < 95) it.opcode = OP_READ;
    else it.opcode = OP_NONE;
    if ($urandom_range(0, 3) != 0) begin
      it.box_left = 17'($urandom_range(0, 65536));
      it.box_top = 17'($urandom_range(0, 65536));
      it.box_width = 17'($urandom_range(0, 65536 - it.box_left));
      it.box_height = 17'($urandom_range(0, 65536 - it.box_top));
      if ($urandom_range(0, 1)) begin
        it.box_width = it.box_width >> $urandom_range(0, 6);
        it.box_height = it.box_height >> $urandom_range(0, 6);
      end
    end
    if ($urandom_range(0, 1)) begin
      it.cell_col = 8'($urandom_range(0, 20));
      it.cell_row = 8'($urandom_range(0, 20));
    end
    return it;
  endfunction

  function automatic logic [63:0] random_pads();
    logic [63:0] p;
    p = {$urandom, $urandom};
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 3))
        0: p[16*k +: 16] = '0;
        1: p[16*k +: 16] = p[16*k +: 16] >> 4;
        default: ;
      endcase
    return p;
  endfunction

  task automatic run_random(int n);
    send_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    repeat (n) send_cmd(random_cmd());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    accepted = 0;
    stall_cycles = 0;
    settings_used = 0;
    allow_gaps = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, nothing enabled
    send_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 255, 255));
    send_cmd(cmd(OP_PAINT, 0, 0, 0, 65536, 65536, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 3, 2));

    apply_setting(13'd100, 13'd70, 7'd16, 7'h3F, 4'hF, 32'h00EC_7F80,
                  64'h0800_1000_FFFF_0000);
    send_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(OP_PAINT, 1, 131071, 131071, 131071, 131071, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 6, 4));
    send_cmd(cmd(OP_PAINT, 2, 20000, 20000, 8000, 8000, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 1, 1));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 2, 2));
    send_cmd(cmd(OP_PAINT, 3, 30000, 30000, 0, 9000, 0, 0));
    send_cmd(cmd(OP_PAINT, 3, 65536, 65536, 0, 0, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 4, 4));
    send_cmd(cmd(OP_PAINT, 0, 0, 0, 65536, 65536, 0, 0));
    send_cmd(cmd(OP_NONE, 3, 131071, 131071, 131071, 131071, 255, 255));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 255, 255));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));

    // smallest grid, out-of-range frame width and block size
    apply_setting(13'd0, 13'd1, 7'd0, 7'h40, 4'h5, 32'h8080_8080,
                  64'h0000_FFFF_0000_0001);
    send_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(OP_PAINT, 2, 0, 0, 1, 1, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 9, 9));

    allow_gaps = 1'b1;
    apply_setting(13'd4096, 13'd8191, 7'd127, 7'h00, 4'hF, {$urandom}, random_pads());
    run_random(40);
    apply_setting(13'd8191, 13'd4096, 7'd16, 7'h4D, 4'hA, 32'hCD33_CD33,
                  64'h0010_0000_0010_0000);
    send_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(OP_PAINT, 1, 0, 0, 65536, 65536, 0, 0));
    send_cmd(cmd(OP_PAINT, 3, 60000, 60000, 5536, 5536, 0, 0));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 255, 255));
    send_cmd(cmd(OP_READ, 0, 0, 0, 0, 0, 128, 7));

    for (int ph = 0; ph < 22; ph++) begin
      apply_setting(13'($urandom_range(1, 256)), 13'($urandom_range(1, 256)),
                    ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(16, 64)),
                    7'($urandom), 4'($urandom), {$urandom}, random_pads());
      if (ph == 21) allow_gaps = 1'b0;
      run_random(ph == 21 ? 150 : 60);
    end

    drain();
    $display("run covered %0d accepted commands over %0d register settings", accepted,
             settings_used);
    $display("%0d read beats checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.readouts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hdl/roiqp_pkg.sv
hdl/roiqp_front.sv
hdl/roiqp_queue.sv
hdl/roiqp_back.sv
hdl/roi_qp_delta_grid_painter_unit.sv
dv/tb_top.sv
